@@ hw/rtl/epte_pkg.sv @@
// ----------------------------------------------------------------------------
// epte_pkg: shared types and constants of the eased property tween engine
// Request and response records, slot record, codes and small helpers.
// ----------------------------------------------------------------------------
package epte_pkg;

  localparam int NODES       = 128;
  localparam int TWEEN_SLOTS = 32;
  localparam int PROPS       = 5;
  localparam int FRAC        = 16;

  localparam int NODE_W = 7;
  localparam int PROP_W = 3;
  localparam int PDEPTH = NODES * PROPS;
  localparam int PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int SA_W   = (TWEEN_SLOTS > 1) ? $clog2(TWEEN_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TWEEN_SLOTS + 1);

  // normalised time and easing weight: FRAC fraction bits, range 0..1
  localparam int XW = FRAC + 1;
  localparam logic [XW-1:0] ONE = XW'(1) << FRAC;

  // request codes
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_CANCEL = 3'd1;
  localparam logic [2:0] REQ_TICK   = 3'd2;
  localparam logic [2:0] REQ_WRITE  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;
  localparam logic [2:0] REQ_DROP   = 3'd5;

  // response kinds
  localparam logic [1:0] K_ACK  = 2'd0;
  localparam logic [1:0] K_UPD  = 2'd1;
  localparam logic [1:0] K_READ = 2'd2;

  // curve codes
  localparam logic [1:0] CV_LINEAR = 2'd0;
  localparam logic [1:0] CV_OUT    = 2'd1;
  localparam logic [1:0] CV_IN     = 2'd2;
  localparam logic [1:0] CV_INOUT  = 2'd3;

  // slot flag bits
  localparam int FL_FIRST  = 0;
  localparam int FL_DONE   = 1;
  localparam int FL_CANCEL = 2;

  typedef logic signed [31:0] val_t;
  typedef val_t [3:0] lanes_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [NODE_W-1:0] node_index;
    logic [PROP_W-1:0] property_req;
    val_t              value_x;
    val_t              value_y;
    val_t              value_z;
    val_t              value_w;
    logic [1:0]        easing;
    logic [31:0]       duration;
    logic [31:0]       delay;
    logic [31:0]       dt;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              status;
    logic [NODE_W-1:0] out_node;
    logic [PROP_W-1:0] out_property;
    val_t              out_x;
    val_t              out_y;
    val_t              out_z;
    val_t              out_w;
    logic              completed;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [PROP_W-1:0] prop;
    lanes_t            start;
    lanes_t            dest;
    logic [31:0]       hold;
    logic [32:0]       elapsed;
    logic [31:0]       span;
    logic [1:0]        curve;
    logic [2:0]        flags;
  } slot_t;

  // Bezier control weights of the eased curves
  function automatic logic [1:0] curve_w1(input logic [1:0] c);
    case (c)
      CV_OUT:   curve_w1 = 2'd3;
      CV_IN:    curve_w1 = 2'd0;
      CV_INOUT: curve_w1 = 2'd0;
      default:  curve_w1 = 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] curve_w2(input logic [1:0] c);
    case (c)
      CV_OUT:   curve_w2 = 2'd3;
      CV_IN:    curve_w2 = 2'd0;
      CV_INOUT: curve_w2 = 2'd3;
      default:  curve_w2 = 2'd2;
    endcase
  endfunction

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    node_ok = int'(n) < NODES;
  endfunction

  function automatic logic addr_ok(input logic [NODE_W-1:0] n, input logic [PROP_W-1:0] p);
    addr_ok = (int'(n) < NODES) && (int'(p) < PROPS);
  endfunction

  function automatic logic [PA_W-1:0] paddr(input logic [NODE_W-1:0] n,
                                            input logic [PROP_W-1:0] p);
    paddr = PA_W'(n) * PA_W'(PROPS) + PA_W'(p);
  endfunction

endpackage

@@ hw/rtl/epte_ram.sv @@
// ----------------------------------------------------------------------------
// epte_ram: generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module epte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/epte_div.sv @@
// ----------------------------------------------------------------------------
// epte_div: normalised time divider
// t = floor(elapsed * 2^FRAC / span) for elapsed <= span, one bit a cycle.
// ----------------------------------------------------------------------------
module epte_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [32:0]           el,
  input  logic [31:0]           span,
  output logic                  done,
  output logic [epte_pkg::XW-1:0] t
);
  import epte_pkg::*;

  localparam int K_W = $clog2(FRAC + 1);

  logic            busy;
  logic            eq;
  logic [K_W-1:0]  k;
  logic [31:0]     rem;
  logic [FRAC-1:0] q;
  logic [32:0]     rem2;
  logic            ge;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, span};
  assign done = busy && (eq || (k == K_W'(FRAC)));
  assign t    = eq ? ONE : XW'(q);

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
      k    <= '0;
      eq   <= el >= {1'b0, span};
      rem  <= el[31:0];
      q    <= '0;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        k   <= k + K_W'(1);
        rem <= ge ? 32'(rem2 - {1'b0, span}) : rem2[31:0];
        q   <= {q[FRAC-2:0], ge};
      end
    end
  end

endmodule

@@ hw/rtl/epte_mix.sv @@
// ----------------------------------------------------------------------------
// epte_mix: easing curve and lane blend
// Evaluates the cubic Bezier weight, then blends four lanes with rounding
// and saturation, on one shared registered multiplier.
// ----------------------------------------------------------------------------
module epte_mix (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [1:0]              curve,
  input  logic [epte_pkg::XW-1:0] t,
  input  epte_pkg::lanes_t        from,
  input  epte_pkg::lanes_t        to,
  output logic                    done,
  output epte_pkg::lanes_t        res
);
  import epte_pkg::*;

  localparam int MA_W  = 33;
  localparam int MB_W  = XW + 1;
  localparam int PW    = MA_W + MB_W;
  localparam int AW    = 2 * XW;
  localparam int SW    = AW + 3;
  localparam int VW    = PW + 1 - FRAC;
  localparam int ST_W  = 5;
  localparam logic [ST_W-1:0] LAST = ST_W'(17);

  logic              busy;
  logic [ST_W-1:0]   step;
  logic [XW-1:0]     u, uu, ut, tt, x, xc, nx;
  logic [AW-1:0]     a, b, c;
  logic [SW-1:0]     sum;
  logic [SW-FRAC-1:0] xs;
  logic signed [MA_W-1:0] opa;
  logic signed [MB_W-1:0] opb;
  logic signed [PW-1:0]   p, acc;
  logic signed [PW:0]     sm;
  logic signed [VW-1:0]   v;
  val_t              vs;
  logic [1:0]        lane;

  assign u    = ONE - t;
  assign nx   = ONE - x;
  assign done = busy && (step == LAST);
  assign lane = step[2:1] - 2'd1;

  // weight sum and clamp to one
  assign sum = SW'(a) * SW'(curve_w1(curve)) + SW'(b) * SW'(curve_w2(curve)) + SW'(c);
  assign xs  = sum[SW-1:FRAC];
  assign xc  = (curve == CV_LINEAR) ? t : ((xs > (SW-FRAC)'(ONE)) ? ONE : XW'(xs));

  // rounded, floored, saturated lane value
  assign sm = (PW+1)'(acc) + (PW+1)'(p) + (PW+1)'(ONE >> 1);
  assign v  = sm[PW:FRAC];
  always_comb begin
    if (v > VW'(32'sh7fffffff)) begin
      vs = 32'sh7fffffff;
    end else if (v < -(VW'(33'sh080000000))) begin
      vs = 32'sh80000000;
    end else begin
      vs = v[31:0];
    end
  end

  // multiplier operands per step
  always_comb begin
    opa = '0;
    opb = '0;
    case (step)
      5'd0: begin opa = $signed(MA_W'(u));  opb = $signed(MB_W'(u)); end
      5'd1: begin opa = $signed(MA_W'(u));  opb = $signed(MB_W'(t)); end
      5'd2: begin opa = $signed(MA_W'(t));  opb = $signed(MB_W'(t)); end
      5'd3: begin opa = $signed(MA_W'(uu)); opb = $signed(MB_W'(t)); end
      5'd4: begin opa = $signed(MA_W'(ut)); opb = $signed(MB_W'(t)); end
      5'd5: begin opa = $signed(MA_W'(tt)); opb = $signed(MB_W'(t)); end
      5'd8, 5'd10, 5'd12, 5'd14: begin
        opa = MA_W'(from[step[2:1]]);
        opb = $signed(MB_W'(nx));
      end
      5'd9, 5'd11, 5'd13, 5'd15: begin
        opa = MA_W'(to[step[2:1]]);
        opb = $signed(MB_W'(x));
      end
      default: ;
    endcase
  end

  // sequencer: issue a product, consume it one step later
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + ST_W'(1);
      if (step == LAST) begin
        busy <= 1'b0;
      end
      p <= opa * opb;
      case (step)
        5'd1: uu <= p[FRAC +: XW];
        5'd2: ut <= p[FRAC +: XW];
        5'd3: tt <= p[FRAC +: XW];
        5'd4: a  <= p[AW-1:0];
        5'd5: b  <= p[AW-1:0];
        5'd6: c  <= p[AW-1:0];
        5'd7: x  <= xc;
        5'd9, 5'd11, 5'd13, 5'd15: acc <= p;
        5'd10, 5'd12, 5'd14, 5'd16: res[lane] <= vs;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/eased_property_tween_engine.sv @@
// ----------------------------------------------------------------------------
// eased_property_tween_engine: tween slot table over a property store
// Top level: request sequencer, property RAM, slot RAM, divider and blender.
// ----------------------------------------------------------------------------
// Usage:
//  Requests arrive on req (req_valid/req_stall); one request is worked at a
//  time and req_stall is high until its last response has been produced.
//  Responses leave on rsp (rsp_valid/rsp_stall) from an output register, so
//  the next request may be taken while the final response is still waiting.
//  Every request ends with a response carrying last; a tick first gives one
//  value update per advancing tween.
//  Start and cancel search the slots, drop visits every slot, and a tick
//  passes over waiting or dead slots; an advancing slot runs the 16 step
//  divider and the 18 step shared multiplier sequence, then a tick ends with
//  a removal sweep over the slots.
//  After reset the property RAM is cleared in a pass over all 640 entries,
//  during which no request is taken. A stalled receiver holds the sequencer
//  in its current response state; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module eased_property_tween_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  epte_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output epte_pkg::rsp_t  rsp
);
  import epte_pkg::*;

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_SRCH_RD  = 5'd2;
  localparam logic [4:0] S_SRCH_CMP = 5'd3;
  localparam logic [4:0] S_START_WR = 5'd4;
  localparam logic [4:0] S_ACK      = 5'd5;
  localparam logic [4:0] S_RD_OUT   = 5'd6;
  localparam logic [4:0] S_RM_RD    = 5'd7;
  localparam logic [4:0] S_RM_CHK   = 5'd8;
  localparam logic [4:0] S_MOVE_WR  = 5'd9;
  localparam logic [4:0] S_TK_RD    = 5'd10;
  localparam logic [4:0] S_TK_CHK   = 5'd11;
  localparam logic [4:0] S_TK_PV    = 5'd12;
  localparam logic [4:0] S_TK_GO    = 5'd13;
  localparam logic [4:0] S_TK_DIV   = 5'd14;
  localparam logic [4:0] S_TK_MIX   = 5'd15;
  localparam logic [4:0] S_TK_OUT   = 5'd16;

  logic [4:0]       state;
  logic [PA_W-1:0]  clr;
  logic [CNT_W-1:0] cnt, idx, cnt_m1;
  logic             status, sweep;
  req_t             rq;
  slot_t            sl, s_wdata, s_rd, upd;
  logic [32:0]      el, el_raw, el_snap;
  logic             out_free, emit;
  rsp_t             em;

  logic             s_we, p_we;
  logic [SA_W-1:0]  s_waddr, s_raddr;
  logic [$bits(slot_t)-1:0]  s_rdata;
  logic [PA_W-1:0]  p_waddr, p_raddr;
  lanes_t           p_wdata, p_rd;
  logic [$bits(lanes_t)-1:0] p_rdata;

  logic             div_go, div_done, mix_go, mix_done;
  logic [XW-1:0]    t;
  lanes_t           mix_res;

  logic             hit, dead, rm_hit, comp;

  epte_ram #(.WIDTH($bits(lanes_t)), .DEPTH(PDEPTH)) u_pram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  epte_ram #(.WIDTH($bits(slot_t)), .DEPTH(TWEEN_SLOTS)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  epte_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .el(el), .span(sl.span),
    .done(div_done), .t(t)
  );

  epte_mix u_mix (
    .clk(clk), .rst(rst), .go(mix_go), .curve(sl.curve), .t(t),
    .from(sl.start), .to(sl.dest), .done(mix_done), .res(mix_res)
  );

  assign s_rd      = slot_t'(s_rdata);
  assign p_rd      = lanes_t'(p_rdata);
  assign req_stall = state != S_IDLE;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign cnt_m1    = cnt - CNT_W'(1);

  // slot tests
  assign hit    = (s_rd.node == rq.node_index) && (s_rd.prop == rq.property_req);
  assign dead   = (s_rd.elapsed >= {1'b0, s_rd.span}) || s_rd.flags[FL_CANCEL];
  assign rm_hit = sweep ? dead : (s_rd.node == rq.node_index);

  // elapsed time after this tick, snapped to the span within half a step
  assign el_raw  = s_rd.flags[FL_FIRST] ? {1'b0, rq.dt - s_rd.hold} : s_rd.elapsed + 33'(rq.dt);
  assign el_snap = ((35'({el_raw, 1'b0}) + 35'(rq.dt)) >= 35'({s_rd.span, 1'b0}))
                   ? {1'b0, s_rd.span} : el_raw;
  assign comp    = (el == {1'b0, sl.span}) && !sl.flags[FL_DONE];

  always_comb begin
    upd                 = sl;
    upd.elapsed         = el;
    upd.flags[FL_FIRST] = 1'b0;
    if (comp) begin
      upd.flags[FL_DONE] = 1'b1;
    end
  end

  // memory ports, unit starts and response
  always_comb begin
    s_we    = 1'b0;
    s_waddr = idx[SA_W-1:0];
    s_wdata = s_rd;
    s_raddr = idx[SA_W-1:0];
    p_we    = 1'b0;
    p_waddr = clr;
    p_wdata = '0;
    p_raddr = paddr(rq.node_index, rq.property_req);
    div_go  = 1'b0;
    mix_go  = 1'b0;
    emit    = 1'b0;
    em      = '0;
    em.out_node     = rq.node_index;
    em.out_property = rq.property_req;
    case (state)
      S_CLEAR: begin
        p_we = 1'b1;
      end
      S_IDLE: begin
        p_raddr = paddr(req.node_index, req.property_req);
        if (req_valid && (req.req_type == REQ_WRITE) &&
            addr_ok(req.node_index, req.property_req)) begin
          p_we    = 1'b1;
          p_waddr = paddr(req.node_index, req.property_req);
          p_wdata = {req.value_w, req.value_z, req.value_y, req.value_x};
        end
      end
      S_SRCH_CMP: begin
        if (hit && (rq.req_type == REQ_CANCEL)) begin
          s_we                     = 1'b1;
          s_wdata.flags[FL_CANCEL] = 1'b1;
        end
      end
      S_START_WR: begin
        s_we            = 1'b1;
        s_wdata.node    = rq.node_index;
        s_wdata.prop    = rq.property_req;
        s_wdata.start   = '0;
        s_wdata.dest    = {rq.value_w, rq.value_z, rq.value_y, rq.value_x};
        s_wdata.hold    = rq.delay;
        s_wdata.elapsed = '0;
        s_wdata.span    = rq.duration;
        s_wdata.curve   = rq.easing;
        s_wdata.flags   = 3'b000;
        s_wdata.flags[FL_FIRST] = 1'b1;
      end
      S_RM_CHK: begin
        if (rm_hit && (idx != cnt_m1)) begin
          s_raddr = cnt_m1[SA_W-1:0];
        end
      end
      S_MOVE_WR: begin
        s_we = 1'b1;
      end
      S_TK_CHK: begin
        if (!dead && !(s_rd.hold < rq.dt)) begin
          s_we         = 1'b1;
          s_wdata.hold = s_rd.hold - rq.dt;
        end
        p_raddr = paddr(s_rd.node, s_rd.prop);
      end
      S_TK_GO: begin
        div_go = 1'b1;
      end
      S_TK_DIV: begin
        mix_go = div_done;
      end
      S_TK_OUT: begin
        emit            = 1'b1;
        em.kind         = K_UPD;
        em.out_node     = sl.node;
        em.out_property = sl.prop;
        em.out_x        = mix_res[0];
        em.out_y        = mix_res[1];
        em.out_z        = mix_res[2];
        em.out_w        = mix_res[3];
        em.completed    = comp;
        if (out_free) begin
          p_we    = 1'b1;
          p_waddr = paddr(sl.node, sl.prop);
          p_wdata = mix_res;
          s_we    = 1'b1;
          s_wdata = upd;
        end
      end
      S_ACK: begin
        emit      = 1'b1;
        em.kind   = K_ACK;
        em.status = status;
        em.last   = 1'b1;
      end
      S_RD_OUT: begin
        emit    = 1'b1;
        em.kind = K_READ;
        em.last = 1'b1;
        if (addr_ok(rq.node_index, rq.property_req)) begin
          em.out_x = p_rd[0];
          em.out_y = p_rd[1];
          em.out_z = p_rd[2];
          em.out_w = p_rd[3];
        end
      end
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (emit && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= em;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + PA_W'(1);
          if (clr == PA_W'(PDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            rq     <= req;
            idx    <= '0;
            status <= 1'b0;
            sweep  <= 1'b0;
            case (req.req_type)
              REQ_START, REQ_CANCEL: begin
                state <= addr_ok(req.node_index, req.property_req) ? S_SRCH_RD : S_ACK;
              end
              REQ_TICK: state <= S_TK_RD;
              REQ_READ: state <= S_RD_OUT;
              REQ_DROP: state <= node_ok(req.node_index) ? S_RM_RD : S_ACK;
              default:  state <= S_ACK;
            endcase
          end
        end
        S_SRCH_RD: begin
          if (idx == cnt) begin
            if (rq.req_type == REQ_START) begin
              if (cnt == CNT_W'(TWEEN_SLOTS)) begin
                status <= 1'b1;
                state  <= S_ACK;
              end else begin
                cnt   <= cnt + CNT_W'(1);
                state <= S_START_WR;
              end
            end else begin
              state <= S_ACK;
            end
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (hit) begin
            state <= (rq.req_type == REQ_START) ? S_START_WR : S_ACK;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_SRCH_RD;
          end
        end
        S_START_WR: state <= S_ACK;
        S_ACK, S_RD_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RM_RD: state <= (idx == cnt) ? S_ACK : S_RM_CHK;
        S_RM_CHK: begin
          if (rm_hit) begin
            cnt   <= cnt_m1;
            state <= (idx == cnt_m1) ? S_RM_RD : S_MOVE_WR;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_RM_RD;
          end
        end
        S_MOVE_WR: state <= S_RM_RD;
        S_TK_RD: begin
          if (idx == cnt) begin
            idx   <= '0;
            sweep <= 1'b1;
            state <= S_RM_RD;
          end else begin
            state <= S_TK_CHK;
          end
        end
        S_TK_CHK: begin
          sl <= s_rd;
          el <= el_snap;
          if (dead || !(s_rd.hold < rq.dt)) begin
            idx   <= idx + CNT_W'(1);
            state <= S_TK_RD;
          end else if (s_rd.flags[FL_FIRST]) begin
            state <= S_TK_PV;
          end else begin
            state <= S_TK_GO;
          end
        end
        S_TK_PV: begin
          sl.start <= p_rd;
          state    <= S_TK_GO;
        end
        S_TK_GO: state <= S_TK_DIV;
        S_TK_DIV: begin
          if (div_done) begin
            state <= S_TK_MIX;
          end
        end
        S_TK_MIX: begin
          if (mix_done) begin
            state <= S_TK_OUT;
          end
        end
        S_TK_OUT: begin
          if (out_free) begin
            idx   <= idx + CNT_W'(1);
            state <= S_TK_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TWEEN_SLOTS))
    else $error("slot count beyond table size");

  a_slot_wr_live: assert property (@(posedge clk) disable iff (rst)
    s_we |-> (CNT_W'(s_waddr) < cnt))
    else $error("slot write outside live slots");

  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.completed) |-> (rsp.kind == K_UPD) && !rsp.last)
    else $error("completion flag on a non-update response");
`endif

endmodule

@@ bench/tween_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tween_scoreboard: response checker for the eased property tween engine
// Watches both channels, keeps its own copy of the property store and the
// tween slot table, predicts the responses of every accepted request and
// compares each response transfer, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module tween_scoreboard
  import epte_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  input  logic   req_stall,
  input  req_t   req,
  input  logic   rsp_valid,
  input  logic   rsp_stall,
  input  rsp_t   rsp,
  output int     errors,
  output int     outstanding
);

  // shadow state
  val_t            store_val [PDEPTH][4];
  int              tw_target [TWEEN_SLOTS];
  val_t            tw_from   [TWEEN_SLOTS][4];
  val_t            tw_to     [TWEEN_SLOTS][4];
  logic [31:0]     tw_hold   [TWEEN_SLOTS];
  longint unsigned tw_elap   [TWEEN_SLOTS];
  logic [31:0]     tw_span   [TWEEN_SLOTS];
  logic [1:0]      tw_curve  [TWEEN_SLOTS];
  logic [2:0]      tw_flags  [TWEEN_SLOTS];
  int              tw_count;

  rsp_t responses_due [$];

  assign outstanding = responses_due.size();

  function automatic rsp_t make_rsp(logic [1:0] kind, logic status, int node, int prop,
                                    val_t x, val_t y, val_t z, val_t w, logic done,
                                    logic fin);
    rsp_t r;
    r.kind = kind;
    r.status = status;
    r.out_node = NODE_W'(node);
    r.out_property = PROP_W'(prop);
    r.out_x = x;
    r.out_y = y;
    r.out_z = z;
    r.out_w = w;
    r.completed = done;
    r.last = fin;
    return r;
  endfunction

  // Bezier weight of normalised time t
  function automatic longint unsigned eased_weight(logic [1:0] curve, longint unsigned t);
    longint unsigned u, uu, ut, tt, x, w1, w2;
    case (curve)
      CV_OUT:   begin w1 = 3; w2 = 3; end
      CV_IN:    begin w1 = 0; w2 = 0; end
      CV_INOUT: begin w1 = 0; w2 = 3; end
      default:  return t;
    endcase
    u = 65536 - t;
    uu = (u * u) >> FRAC;
    ut = (u * t) >> FRAC;
    tt = (t * t) >> FRAC;
    x = (w1 * uu * t + w2 * ut * t + tt * t) >> FRAC;
    return (x > 65536) ? 65536 : x;
  endfunction

  // rounded mix of two lanes, saturated to s15.16
  function automatic val_t lane_mix(val_t from, val_t to, longint unsigned x);
    longint s;
    s = longint'(from) * (65536 - longint'(x)) + longint'(to) * longint'(x) + 32768;
    s = s >>> FRAC;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return val_t'(s);
  endfunction

  function automatic logic tween_dead(int i);
    return tw_elap[i] >= longint'(tw_span[i]) || tw_flags[i][FL_CANCEL];
  endfunction

  function automatic void drop_tween(int i);
    tw_count--;
    if (i != tw_count) begin
      tw_target[i] = tw_target[tw_count];
      tw_from[i]   = tw_from[tw_count];
      tw_to[i]     = tw_to[tw_count];
      tw_hold[i]   = tw_hold[tw_count];
      tw_elap[i]   = tw_elap[tw_count];
      tw_span[i]   = tw_span[tw_count];
      tw_curve[i]  = tw_curve[tw_count];
      tw_flags[i]  = tw_flags[tw_count];
    end
  endfunction

  // work out the responses of one request and advance the shadow state
  function automatic void predict_request(req_t r);
    int node, prop, tg, i;
    logic ok, status;
    val_t lanes[4];
    val_t res[4];
    longint unsigned el, t, x;
    logic done;
    node = int'(r.node_index);
    prop = int'(r.property_req);
    ok = node < NODES && prop < PROPS;
    tg = ok ? node * PROPS + prop : 0;
    status = 1'b0;
    lanes = '{r.value_x, r.value_y, r.value_z, r.value_w};
    case (r.req_type)
      REQ_START: if (ok) begin
        for (i = 0; i < tw_count; i++) if (tw_target[i] == tg) break;
        if (i == tw_count) begin
          if (tw_count >= TWEEN_SLOTS) status = 1'b1;
          else tw_count++;
        end
        if (!status) begin
          tw_target[i] = tg;
          tw_to[i] = lanes;
          tw_hold[i] = r.delay;
          tw_elap[i] = 0;
          tw_span[i] = r.duration;
          tw_curve[i] = r.easing;
          tw_flags[i] = 3'b001;
        end
      end
      REQ_CANCEL: if (ok) begin
        for (i = 0; i < tw_count; i++)
          if (tw_target[i] == tg) begin
            tw_flags[i][FL_CANCEL] = 1'b1;
            break;
          end
      end
      REQ_TICK: begin
        for (i = 0; i < tw_count; i++) begin
          if (tween_dead(i)) continue;
          if (!(tw_hold[i] < r.dt)) begin
            tw_hold[i] -= r.dt;
            continue;
          end
          if (tw_flags[i][FL_FIRST]) begin
            tw_from[i] = store_val[tw_target[i]];
            tw_flags[i][FL_FIRST] = 1'b0;
            el = longint'(r.dt - tw_hold[i]);
          end else begin
            el = tw_elap[i] + r.dt;
          end
          if (2 * el + r.dt >= 2 * longint'(tw_span[i])) el = tw_span[i];
          tw_elap[i] = el;
          t = (el << FRAC) / longint'(tw_span[i]);
          x = eased_weight(tw_curve[i], t);
          for (int j = 0; j < 4; j++) res[j] = lane_mix(tw_from[i][j], tw_to[i][j], x);
          store_val[tw_target[i]] = res;
          done = 1'b0;
          if (el == longint'(tw_span[i]) && !tw_flags[i][FL_DONE]) begin
            tw_flags[i][FL_DONE] = 1'b1;
            done = 1'b1;
          end
          responses_due.push_back(make_rsp(K_UPD, 1'b0, tw_target[i] / PROPS,
            tw_target[i] % PROPS, res[0], res[1], res[2], res[3], done, 1'b0));
        end
        i = 0;
        while (i < tw_count) begin
          if (tween_dead(i)) drop_tween(i);
          else i++;
        end
      end
      REQ_WRITE: if (ok) store_val[tg] = lanes;
      REQ_READ: begin
        if (ok) res = store_val[tg];
        else res = '{default: '0};
        responses_due.push_back(make_rsp(K_READ, 1'b0, node, prop,
          res[0], res[1], res[2], res[3], 1'b0, 1'b1));
        return;
      end
      REQ_DROP: if (node < NODES) begin
        i = 0;
        while (i < tw_count) begin
          if (tw_target[i] / PROPS == node) drop_tween(i);
          else i++;
        end
      end
      default: ;
    endcase
    responses_due.push_back(make_rsp(K_ACK, status, node, prop, '0, '0, '0, '0, 1'b0,
                                     1'b1));
  endfunction

  // compare response transfers, then predict from request transfers
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (store_val[a]) store_val[a] = '{default: '0};
      tw_count = 0;
      responses_due.delete();
      errors = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (responses_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected response kind=%0d node=%0d prop=%0d", $realtime,
                     rsp.kind, rsp.out_node, rsp.out_property);
        end else begin
          want = responses_due.pop_front();
          if (rsp.kind !== want.kind || rsp.status !== want.status ||
              rsp.out_node !== want.out_node || rsp.out_property !== want.out_property ||
              rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
              rsp.out_z !== want.out_z || rsp.out_w !== want.out_w ||
              rsp.completed !== want.completed || rsp.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch kind/status/node/prop/done/last", $realtime);
              $display("  exp %0d %0d %0d %0d %0d %0d lanes %h %h %h %h", want.kind,
                       want.status, want.out_node, want.out_property, want.completed,
                       want.last, want.out_x, want.out_y, want.out_z, want.out_w);
              $display("  got %0d %0d %0d %0d %0d %0d lanes %h %h %h %h", rsp.kind,
                       rsp.status, rsp.out_node, rsp.out_property, rsp.completed,
                       rsp.last, rsp.out_x, rsp.out_y, rsp.out_z, rsp.out_w);
            end
          end
        end
      end
      if (req_valid && !req_stall) predict_request(req);
    end
  end

endmodule

@@ bench/eased_property_tween_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_property_tween_engine_tb: top level of the tween engine testbench
// Drives a directed opening and then random request traffic with bursts and
// gaps, stalls the response side on its own pattern (one long hold included)
// and gives the verdict from the scoreboard's error and outstanding counts.
// ----------------------------------------------------------------------------
module eased_property_tween_engine_tb;
  import epte_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  int   errors, outstanding;
  int   cycles = 0;
  int   burst_left = 0;

  always #5 clk = ~clk;

  eased_property_tween_engine dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  tween_scoreboard checker_i (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .errors(errors), .outstanding(outstanding)
  );

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // response side: random stall pattern, one long hold-off, calm stretches
  initial begin
    int mode;
    bit long_hold_done;
    long_hold_done = 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      if (!long_hold_done && cycles > 3000) begin
        long_hold_done = 1'b1;
        repeat (600) @(negedge clk) rsp_stall <= 1'b1;
      end else begin
        repeat ($urandom_range(20, 120)) @(negedge clk)
          rsp_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
      end
    end
  end

  // one request transfer; valid stays high inside a burst
  task automatic send_request(req_t r);
    if (burst_left == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    req = r;
    req_valid = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic req_t make_req(logic [2:0] kind, int node, int prop, logic [1:0] curve,
                                    logic [31:0] dur, logic [31:0] dly, logic [31:0] step);
    req_t r;
    r.req_type = kind;
    r.node_index = NODE_W'(node);
    r.property_req = PROP_W'(prop);
    r.value_x = $urandom;
    r.value_y = $urandom;
    r.value_z = $urandom;
    r.value_w = $urandom;
    r.easing = curve;
    r.duration = dur;
    r.delay = dly;
    r.dt = step;
    return r;
  endfunction

  // random request drawn mostly over a small pool of properties
  function automatic req_t random_req();
    int pick, node, prop;
    logic [2:0] kind;
    logic [31:0] dur, dly, step;
    pick = $urandom_range(0, 99);
    node = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
    prop = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    dur = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 32'h40000);
    dly = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h10000) : 32'h0;
    if ($urandom_range(0, 19) == 0) dly = $urandom;
    step = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 32'h8000);
    if (pick < 30) kind = REQ_START;
    else if (pick < 60) kind = REQ_TICK;
    else if (pick < 72) kind = REQ_READ;
    else if (pick < 82) kind = REQ_WRITE;
    else if (pick < 90) kind = REQ_CANCEL;
    else if (pick < 95) kind = REQ_DROP;
    else kind = 3'($urandom_range(6, 7));
    return make_req(kind, node, prop, 2'($urandom_range(0, 3)), dur, dly, step);
  endfunction

  initial begin
    req_t r;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed opening: extremes, each operation and the corner cases
    r = make_req(REQ_WRITE, 0, 0, CV_LINEAR, 0, 0, 0);
    r.value_x = 32'sh7FFFFFFF; r.value_y = 32'sh80000000;
    r.value_z = 32'sh0;        r.value_w = -32'sd1;
    send_request(r);
    send_request(make_req(REQ_READ, 0, 0, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_READ, 3, 7, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_WRITE, 127, 4, CV_LINEAR, 0, 0, 0));
    r = make_req(REQ_START, 0, 0, CV_LINEAR, 32'h10000, 0, 0);
    r.value_x = 32'sh80000000; r.value_y = 32'sh7FFFFFFF;
    send_request(r);
    send_request(make_req(REQ_START, 0, 1, CV_OUT, 32'h10000, 0, 0));
    send_request(make_req(REQ_START, 0, 2, CV_IN, 32'h18000, 0, 0));
    send_request(make_req(REQ_START, 0, 3, CV_INOUT, 32'h10000, 32'h8000, 0));
    send_request(make_req(REQ_START, 1, 0, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_START, 127, 4, CV_OUT, 32'hFFFFFFFF, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, CV_LINEAR, 0, 0, 32'h4000));
    send_request(make_req(REQ_CANCEL, 0, 1, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_CANCEL, 5, 0, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, CV_LINEAR, 0, 0, 32'h8000));
    send_request(make_req(REQ_START, 0, 0, CV_INOUT, 32'h20000, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, CV_LINEAR, 0, 0, 32'h10000));
    send_request(make_req(REQ_DROP, 0, 3, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, CV_LINEAR, 0, 0, 32'h40000));
    send_request(make_req(3'd6, 2, 2, CV_LINEAR, 0, 0, 0));
    send_request(make_req(3'd7, 2, 2, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_START, 4, 6, CV_LINEAR, 32'h10000, 0, 0));
    send_request(make_req(REQ_WRITE, 4, 5, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_READ, 0, 0, CV_LINEAR, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, CV_LINEAR, 0, 0, 32'hFFFFFFFF));

    // random traffic, with a table fill to overflow in the middle
    for (int n = 0; n < 220; n++) begin
      if (n == 110) begin
        for (int k = 0; k < 34; k++)
          send_request(make_req(REQ_START, 10 + k / PROPS, k % PROPS,
                                2'($urandom_range(0, 3)), $urandom_range(1, 32'h30000), 0, 0));
        send_request(make_req(REQ_TICK, 0, 0, CV_LINEAR, 0, 0, 32'h8000));
        send_request(make_req(REQ_TICK, 0, 0, CV_LINEAR, 0, 0, 32'h7FFFFFFF));
      end
      send_request(random_req());
    end
    req_valid = 1'b0;

    // drain, then allow for the block's own latency
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
